// ===== design/escid_pkg.sv =====
`default_nettype none
package escid_pkg;

  localparam int unsigned PREFIX_LEN = 7;
  localparam int unsigned TAG_LEN = 6;

  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0] ESC_PREFIX [PREFIX_LEN] = '{
    8'h2B, 8'h2B, 8'h2B, 8'h43, 8'h46, 8'h47, 8'h3A
  };

  localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{
    8'h52, 8'h4F, 8'h54, 8'h4F, 8'h52, 8'h2D
  };

  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/escid_byte_if.sv =====
`default_nettype none
interface escid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface
`default_nettype wire

// ===== design/escid_result_if.sv =====
`default_nettype none
interface escid_result_if;
  logic valid;
  logic ready;
  logic config_request_hit;
  logic config_request_miss;

  modport source (output valid, output config_request_hit, output config_request_miss,
                  input ready);
  modport sink (input valid, input config_request_hit, input config_request_miss,
                output ready);
endinterface
`default_nettype wire

// ===== design/escape_sequence_id_detector.sv =====
`default_nettype none
// Channel     Role    Payload
// byte_in     sink    stream_byte[7:0]
// result_out  source  config_request_hit, config_request_miss
// cfg         write   cfg_we, cfg_index[0], cfg_data[63:0]
//
// Each accepted byte yields one result, registered and available on the next cycle.
// A byte can be accepted every cycle when not stalled; the single result register sets the rate.
// A stalled result holds the input off only while the result register is full.
// Reset clears the sequence count, the identifier and the result valid, and sets the match flags.
module escape_sequence_id_detector
  import escid_pkg::*;
#(
  parameter int unsigned UID_LEN = 12,
  parameter int unsigned SEQ_BUFFER_BYTES = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  escid_byte_if.sink       byte_in,
  escid_result_if.source   result_out,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int unsigned CW = $clog2(SEQ_BUFFER_BYTES);
  localparam logic [7:0] PLAIN_END = 8'(PREFIX_LEN + UID_LEN);
  localparam logic [7:0] TAGGED_END = 8'(PREFIX_LEN + TAG_LEN + UID_LEN);
  localparam logic [CW-1:0] COUNT_LAST = CW'(SEQ_BUFFER_BYTES - 1);
  localparam logic [CW-1:0] COUNT_PREFIX = CW'(PREFIX_LEN);

  localparam logic CFG_UID_FIRST = 1'b0;
  localparam logic CFG_UID_LAST = 1'b1;

  logic [63:0]   uid_first;
  logic [31:0]   uid_last;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          plain_ok;
  logic          plain_ok_next;
  logic          tag_ok;
  logic          tag_ok_next;
  logic          res_valid;
  logic          res_hit;
  logic          res_hit_next;
  logic          res_miss;
  logic          res_miss_next;

  logic          accept;
  logic [7:0]    fc;
  logic [7:0]    count_ext;
  logic [CW-1:0] id_pos;
  logic          in_prefix;
  logic          is_term;
  logic          plain_eq;
  logic          tag_eq;

  assign accept = byte_in.valid && byte_in.ready;
  assign byte_in.ready = !res_valid || result_out.ready;
  assign fc = fold(byte_in.stream_byte);
  assign count_ext = 8'(count);
  assign id_pos = count - COUNT_PREFIX;
  assign in_prefix = (count < COUNT_PREFIX);
  assign is_term = (byte_in.stream_byte == CHAR_CR) || (byte_in.stream_byte == CHAR_LF);

  escid_id_match #(
    .UID_LEN(UID_LEN),
    .POS_W  (CW)
  ) u_match (
    .uid_first(uid_first),
    .uid_last (uid_last),
    .pos      (id_pos),
    .fc       (fc),
    .plain_eq (plain_eq),
    .tag_eq   (tag_eq)
  );

  always_comb begin
    count_next = count;
    plain_ok_next = plain_ok;
    tag_ok_next = tag_ok;
    res_hit_next = 1'b0;
    res_miss_next = 1'b0;
    if (in_prefix) begin
      plain_ok_next = 1'b1;
      tag_ok_next = 1'b1;
      if (byte_in.stream_byte == ESC_PREFIX[count[2:0]]) begin
        count_next = count + CW'(1);
      end else if (byte_in.stream_byte == CHAR_PLUS) begin
        count_next = CW'(1);
      end else begin
        count_next = '0;
      end
    end else if (is_term) begin
      res_hit_next = (plain_ok && count_ext == PLAIN_END) ||
                     (tag_ok && count_ext == TAGGED_END);
      res_miss_next = !res_hit_next;
      count_next = '0;
    end else if (count < COUNT_LAST) begin
      plain_ok_next = plain_ok && (count_ext < PLAIN_END) && plain_eq;
      tag_ok_next = tag_ok && (count_ext < TAGGED_END) && tag_eq;
      count_next = count + CW'(1);
    end else begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      uid_first <= '0;
      uid_last <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_UID_FIRST) begin
        uid_first <= cfg_data;
      end else if (cfg_index == CFG_UID_LAST) begin
        uid_last <= cfg_data[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      plain_ok <= 1'b1;
      tag_ok <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        count <= count_next;
        plain_ok <= plain_ok_next;
        tag_ok <= tag_ok_next;
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit <= res_hit_next;
      res_miss <= res_miss_next;
    end
  end

  assign result_out.valid = res_valid;
  assign result_out.config_request_hit = res_hit;
  assign result_out.config_request_miss = res_miss;

  a_hit_miss_excl: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> !(result_out.config_request_hit && result_out.config_request_miss))
    else $error("hit and miss raised together");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_prefix && is_term) |=> (count == '0))
    else $error("terminator did not restart the sequence");

  a_prefix_flags: assert property (@(posedge clk) disable iff (rst)
    (accept && in_prefix) |=> (plain_ok && tag_ok))
    else $error("match flags not restored during prefix");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_LAST)
    else $error("sequence count beyond buffer");

endmodule
`default_nettype wire

// ===== design/escid_id_match.sv =====
`default_nettype none
module escid_id_match
  import escid_pkg::*;
#(
  parameter int unsigned UID_LEN = 12,
  parameter int unsigned POS_W = 6
) (
  input  wire logic [63:0]      uid_first,
  input  wire logic [31:0]      uid_last,
  input  wire logic [POS_W-1:0] pos,
  input  wire logic [7:0]       fc,
  output logic                  plain_eq,
  output logic                  tag_eq
);

  localparam logic [POS_W-1:0] POS_UID_END = POS_W'(UID_LEN);
  localparam logic [POS_W-1:0] POS_TAG_END = POS_W'(TAG_LEN);

  // The expected character comes from the tag text or live identifier by the name position.
  logic [7:0]       uid_folded [12];
  logic [POS_W-1:0] tag_pos;

  assign tag_pos = pos - POS_TAG_END;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      uid_folded[k] = fold(uid_first[8*k +: 8]);
    end
    for (int k = 0; k < 4; k++) begin
      uid_folded[8+k] = fold(uid_last[8*k +: 8]);
    end
  end

  always_comb begin
    plain_eq = 1'b0;
    tag_eq = 1'b0;
    if (pos < POS_UID_END) begin
      plain_eq = (uid_folded[pos[3:0]] == fc);
    end
    if (pos < POS_TAG_END) begin
      tag_eq = (fold(TAG_TEXT[pos[2:0]]) == fc);
    end else if (tag_pos < POS_UID_END) begin
      tag_eq = (uid_folded[tag_pos[3:0]] == fc);
    end
  end

endmodule
`default_nettype wire
